/* rtl/msp_pkg.sv */
// ---------------------------------------------------------------------------
// msp_pkg: shared definitions for the magnet pulse speed/position estimator
// Field widths, fixed-point constants, item kinds and sequencer states.
// ---------------------------------------------------------------------------
package msp_pkg;

  // Default widths of the timer and of the encoder count.
  localparam int TIMER_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int MAG_W = 6;
  localparam int RPM_W = 34;
  localparam int POS_W = 18;
  localparam int FRAC_W = 17;
  localparam int OUT_FIELDS_W = RPM_W + POS_W + MAG_W + 1;
  localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Shared divider geometry.
  localparam int DIV_DVD_W = 34;
  localparam int DIV_CNT_W = 6;
  localparam int POS_NUM_W = 23;
  localparam logic [DIV_CNT_W-1:0] RPM_STEPS = DIV_CNT_W'(DIV_DVD_W);
  localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = DIV_CNT_W'(16);
  localparam logic [DIV_CNT_W-1:0] POS_STEPS = DIV_CNT_W'(POS_NUM_W);

  // Fixed-point constants.
  localparam logic [RPM_W-1:0] RPM_NUM_Q8 = 34'd15360000000;
  localparam logic [63:0] PERIOD_RESET = 64'd10000000;
  localparam logic [MAG_W-1:0] MAGNETS_RESET = 6'd6;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  // Item kinds carried on tuser.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_RPM_GO,
    S_RPM_WAIT,
    S_FRAC_GO,
    S_FRAC_WAIT,
    S_POS_GO,
    S_POS_WAIT,
    S_OUT
  } state_t;

endpackage

/* rtl/msp_track.sv */
// ---------------------------------------------------------------------------
// msp_track: rotor tracking state
// Saturating microsecond timer, latched magnet period, magnet index and
// rotation direction.
// ---------------------------------------------------------------------------
module msp_track
  import msp_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          enc_evt,
  input  logic signed [COUNT_WIDTH-1:0] count,
  input  logic [MAG_W-1:0]              n_eff,
  output logic [TIMER_WIDTH-1:0]        period,
  output logic [TIMER_WIDTH-1:0]        since,
  output logic [MAG_W-1:0]              index,
  output logic                          reverse
);

  localparam logic [TIMER_WIDTH-1:0] PERIOD_INIT = PERIOD_RESET[TIMER_WIDTH-1:0];

  logic signed [COUNT_WIDTH-1:0] last_count;
  logic [MAG_W:0]                index_inc;

  assign index_inc = {1'b0, index} + {{MAG_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_INIT;
      since      <= '0;
      last_count <= '0;
      index      <= '0;
      reverse    <= 1'b0;
    end else if (enc_evt) begin
      // Greater count steps forward, anything else steps backward.
      if (count > last_count) begin
        reverse <= 1'b0;
        index   <= (index_inc >= {1'b0, n_eff}) ? '0 : index_inc[MAG_W-1:0];
      end else begin
        reverse <= 1'b1;
        index   <= (index == '0) ? n_eff - 1'b1 : index - 1'b1;
      end
      last_count <= count;
      period     <= since;
      since      <= '0;
    end else if (tick && (since != '1)) begin
      since <= since + 1'b1;
    end
  end

endmodule

/* rtl/msp_divider.sv */
// ---------------------------------------------------------------------------
// msp_divider: shared restoring divider
// One quotient bit per cycle, dividend shifted in MSB first, remainder can
// be preloaded to resume a division part way through.
// ---------------------------------------------------------------------------
module msp_divider
  import msp_pkg::*;
#(
  parameter int REM_W = TIMER_WIDTH_DEF + MAG_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [REM_W-1:0]     preload,
  input  logic [REM_W-1:0]     divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient,
  output logic [REM_W-1:0]     remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DVD_W-1:0] dvd;
  logic [REM_W-1:0]     dsr;
  logic [REM_W:0]       trial;
  logic                 fits;

  assign trial = {remainder, dvd[DIV_DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= preload;
      dvd       <= dividend;
      dsr       <= divisor;
      quotient  <= '0;
      cnt       <= steps;
    end else if (busy) begin
      remainder <= fits ? trial[REM_W-1:0] - dsr : trial[REM_W-1:0];
      dvd       <= {dvd[DIV_DVD_W-2:0], 1'b0};
      quotient  <= {quotient[DIV_DVD_W-2:0], fits};
      cnt       <= cnt - 1'b1;
    end
  end

endmodule

/* rtl/magnet_pulse_speed_position_estimator.sv */
// ---------------------------------------------------------------------------
// magnet_pulse_speed_position_estimator: period-based tachometer
// Flow: ticks and encoder events are taken back to back while idle; a query runs
//   a multiply, then the shared divider for rpm (34 steps), the fraction (16 steps,
//   skipped when the timer has passed the period) and the position (23 steps).
// Input is held while a query runs; a new item is taken only once its result is loaded.
// Reset: synchronous, active high; period 10000000, timer, index, direction
//   cleared, magnet count 6, output empty.
// ---------------------------------------------------------------------------
module magnet_pulse_speed_position_estimator
  import msp_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: magnet count
  input  logic                                 cfg_wr_en,
  input  logic [MAG_W-1:0]                     cfg_wr_data,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: encoder_count
  input  logic [((COUNT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: kind
  input  logic [1:0]                           s_axis_tuser,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: rpm_q8, position_q16, magnet_index_out, reverse, zero pad
  output logic [OUT_W-1:0]                     m_axis_tdata
);

  localparam int PROD_W = TIMER_WIDTH + MAG_W;
  localparam logic signed [24:0] POS_HI = 25'sd65536;
  localparam logic signed [24:0] POS_LO = -25'sd65536;

  // Configuration register.
  logic [MAG_W-1:0] magnet_count;
  logic [MAG_W-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnet_count <= MAGNETS_RESET;
    end else if (cfg_wr_en) begin
      magnet_count <= cfg_wr_data;
    end
  end

  // Zero magnets behaves as one.
  assign n_eff = (magnet_count == '0) ? MAG_W'(1) : magnet_count;

  // Input transaction decode.
  state_t state, state_next;
  logic   in_fire;
  logic   tick;
  logic   enc_evt;
  logic   query;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign tick    = in_fire && (s_axis_tuser == KIND_TICK);
  assign enc_evt = in_fire && (s_axis_tuser == KIND_EVENT);
  assign query   = in_fire && (s_axis_tuser == KIND_QUERY);

  // Rotor tracking.
  logic [TIMER_WIDTH-1:0] period;
  logic [TIMER_WIDTH-1:0] since;
  logic [MAG_W-1:0]       index;
  logic                   reverse;

  msp_track #(
    .TIMER_WIDTH(TIMER_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .enc_evt (enc_evt),
    .count   ($signed(s_axis_tdata[COUNT_WIDTH-1:0])),
    .n_eff   (n_eff),
    .period  (period),
    .since   (since),
    .index   (index),
    .reverse (reverse)
  );

  // Zero period behaves as one; tracking state holds while a query runs.
  logic [TIMER_WIDTH-1:0] p_eff;
  logic                   since_ge;

  assign p_eff    = (period == '0) ? TIMER_WIDTH'(1) : period;
  assign since_ge = since >= p_eff;

  // Shared divider.
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [PROD_W-1:0]    div_preload;
  logic [PROD_W-1:0]    div_divisor;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] div_quotient;
  logic [PROD_W-1:0]    div_remainder;

  msp_divider #(
    .REM_W(PROD_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .preload   (div_preload),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Working registers of a query.
  logic [PROD_W-1:0]    prod;
  logic [RPM_W-1:0]     rpm;
  logic [FRAC_W-1:0]    frac;
  logic                 pos_neg;
  logic [POS_W-1:0]     pos;

  // Position numerator: index*65536 plus or minus the fraction.
  logic signed [23:0]        pos_num;
  logic signed [23:0]        frac_s;
  logic [POS_NUM_W-1:0]      pos_mag;
  logic signed [24:0]        pos_q;
  logic signed [24:0]        pos_full;
  logic [POS_W-1:0]          pos_sat;

  assign frac_s  = $signed({7'b0, frac});
  assign pos_num = $signed({2'b0, index, 16'b0}) + (reverse ? -frac_s : frac_s);
  assign pos_mag = pos_num[23] ? POS_NUM_W'(-pos_num) : pos_num[POS_NUM_W-1:0];

  // Floor division of a negative numerator rounds the magnitude up.
  assign pos_q    = $signed({2'b0, div_quotient[POS_NUM_W-1:0]});
  assign pos_full = pos_neg ? -pos_q - $signed({24'b0, div_remainder != '0}) : pos_q;

  always_comb begin
    if (pos_full > POS_HI) begin
      pos_sat = POS_HI[POS_W-1:0];
    end else if (pos_full < POS_LO) begin
      pos_sat = POS_LO[POS_W-1:0];
    end else begin
      pos_sat = pos_full[POS_W-1:0];
    end
  end

  // Divider operand selection per phase.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_preload  = '0;
    div_divisor  = PROD_W'(1);
    div_steps    = RPM_STEPS;
    case (state)
      S_RPM_GO: begin
        div_start    = 1'b1;
        div_dividend = RPM_NUM_Q8;
        div_divisor  = prod;
        div_steps    = RPM_STEPS;
      end
      S_FRAC_GO: begin
        // Resume since*65536/period after the integer part, known to be zero.
        div_start    = 1'b1;
        div_preload  = PROD_W'(since);
        div_divisor  = PROD_W'(p_eff);
        div_steps    = FRAC_STEPS;
      end
      S_POS_GO: begin
        div_start    = 1'b1;
        div_dividend = {pos_mag, {(DIV_DVD_W - POS_NUM_W){1'b0}}};
        div_divisor  = PROD_W'(n_eff);
        div_steps    = POS_STEPS;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query) begin
          state_next = S_MUL;
        end
      end
      S_MUL:       state_next = S_RPM_GO;
      S_RPM_GO:    state_next = S_RPM_WAIT;
      S_RPM_WAIT: begin
        if (div_done) begin
          state_next = since_ge ? S_POS_GO : S_FRAC_GO;
        end
      end
      S_FRAC_GO:   state_next = S_FRAC_WAIT;
      S_FRAC_WAIT: begin
        if (div_done) begin
          state_next = S_POS_GO;
        end
      end
      S_POS_GO:    state_next = S_POS_WAIT;
      S_POS_WAIT: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the result slot is free.
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Query datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= PROD_W'(n_eff * p_eff);
    end
    if ((state == S_RPM_WAIT) && div_done) begin
      rpm <= div_quotient[RPM_W-1:0];
      if (since_ge) begin
        frac <= FRAC_ONE;
      end
    end
    if ((state == S_FRAC_WAIT) && div_done) begin
      frac <= div_quotient[FRAC_W-1:0];
    end
    if (state == S_POS_GO) begin
      pos_neg <= pos_num[23];
    end
    if ((state == S_POS_WAIT) && div_done) begin
      pos <= pos_sat;
    end
  end

  // Result transaction: load wins over drain in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_axis_tdata <= {{(OUT_W - OUT_FIELDS_W){1'b0}}, reverse, index, pos, rpm};
    end
  end

endmodule

/* sim/rotor_estimate_check.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rotor_estimate_check: result predictor and comparator for the estimator
// Tracks timer, period, magnet index, direction and magnet count from the
// accepted input and configuration transactions, predicts each query's
// speed/position result and compares it field by field with the output.
// ---------------------------------------------------------------------------
module rotor_estimate_check
  import msp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [MAG_W-1:0]           cfg_wr_data,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [COUNT_WIDTH_DEF-1:0] s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [OUT_W-1:0]           m_tdata,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [POS_W-1:0] pos;
    logic [MAG_W-1:0] idx;
    logic             rev;
  } estimate_t;

  estimate_t                         estimates_due[$];
  logic [TIMER_WIDTH_DEF-1:0]        period_q;
  logic [TIMER_WIDTH_DEF-1:0]        timer_q;
  logic signed [COUNT_WIDTH_DEF-1:0] last_cnt;
  logic [MAG_W-1:0]                  mag_idx;
  logic [MAG_W-1:0]                  magnets;
  logic                              rev_q;

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    longint    n_eff;
    longint    p;
    longint    since;
    longint    frac;
    longint    num;
    longint    pos;
    estimate_t want;
    estimate_t got;
    if (rst) begin
      period_q = TIMER_WIDTH_DEF'(PERIOD_RESET);
      timer_q  = '0;
      last_cnt = '0;
      mag_idx  = '0;
      rev_q    = 1'b0;
      magnets  = MAGNETS_RESET;
      estimates_due.delete();
      errors   = 0;
    end else begin
      n_eff = (magnets == 0) ? 1 : longint'(magnets);

      if (s_tvalid && s_tready) begin
        case (s_tuser)
          KIND_TICK: begin
            if (timer_q != '1) timer_q = timer_q + 1'b1;
          end
          KIND_EVENT: begin
            // an equal count counts as reverse
            if ($signed(s_tdata) > last_cnt) begin
              rev_q   = 1'b0;
              mag_idx = (longint'(mag_idx) + 1 >= n_eff) ? '0 : mag_idx + 1'b1;
            end else begin
              rev_q   = 1'b1;
              mag_idx = (mag_idx == 0) ? MAG_W'(n_eff - 1) : mag_idx - 1'b1;
            end
            last_cnt = $signed(s_tdata);
            period_q = timer_q;
            timer_q  = '0;
          end
          KIND_QUERY: begin
            p     = (period_q == 0) ? 1 : longint'(period_q);
            since = (longint'(timer_q) < p) ? longint'(timer_q) : p;
            frac  = (since << 16) / p;
            num   = longint'(mag_idx) * 65536 + (rev_q ? -frac : frac);
            pos   = (num >= 0) ? num / n_eff : -((-num + n_eff - 1) / n_eff);
            if (pos > 65536) pos = 65536;
            if (pos < -65536) pos = -65536;
            want.rpm = RPM_W'(longint'(RPM_NUM_Q8) / (n_eff * p));
            want.pos = POS_W'(pos);
            want.idx = mag_idx;
            want.rev = rev_q;
            estimates_due.push_back(want);
          end
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.rpm = m_tdata[RPM_W-1:0];
        got.pos = m_tdata[RPM_W +: POS_W];
        got.idx = m_tdata[RPM_W+POS_W +: MAG_W];
        got.rev = m_tdata[RPM_W+POS_W+MAG_W];
        if (estimates_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
        end else begin
          want = estimates_due.pop_front();
          compare_field("rpm_q8", longint'(want.rpm), longint'(got.rpm));
          compare_field("position_q16", longint'($signed(want.pos)), longint'($signed(got.pos)));
          compare_field("magnet_index_out", longint'(want.idx), longint'(got.idx));
          compare_field("reverse", longint'(want.rev), longint'(got.rev));
        end
      end

      // a register write takes effect after this edge's transactions
      if (cfg_wr_en) magnets = cfg_wr_data;
    end
    pending = estimates_due.size();
  end

endmodule

/* sim/tb_magnet_pulse_speed_position_estimator.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_magnet_pulse_speed_position_estimator: regression for the tachometer
// Drives ticks, encoder events and queries through the input stream under
// several magnet counts, with random gaps on both sides and one long output
// stall; a side module predicts and checks every query result.
// ---------------------------------------------------------------------------
module tb_magnet_pulse_speed_position_estimator;
  import msp_pkg::*;

  localparam int        CNT_W        = ((COUNT_WIDTH_DEF + 7) / 8) * 8;
  localparam logic [1:0] KIND_NONE   = 2'd3;   // undefined kind, must be ignored
  localparam int        DRAIN_CYCLES = 120;    // longer than a query takes
  localparam int        HOLD_CYCLES  = 400;    // long output stall
  localparam int        CYCLE_LIMIT  = 1000000;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [MAG_W-1:0]   cfg_wr_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [CNT_W-1:0]   s_axis_tdata = '0;       // encoder_count
  logic [1:0]         s_axis_tuser = KIND_TICK; // kind
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;            // rpm_q8, position_q16, index, reverse

  int                 errors;
  int                 pending;
  int                 sent = 0;
  int                 cycle_cnt = 0;
  bit                 gaps_on = 1'b1;
  int                 hold_token = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  logic signed [15:0] prev_cnt = '0;  // last count sent, shapes rotation runs

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  magnet_pulse_speed_position_estimator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rotor_estimate_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .errors      (errors),
    .pending     (pending)
  );

  // Receiver: random back-pressure, or a long hold-off each time the
  // stimulus bumps hold_token. The hold is counted here, not by the sender.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !gaps_on || ($urandom_range(99) >= 7);
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until the transaction completes. Random idle
  // cycles go in front of it; valid stays high between back-to-back items.
  task automatic send_item(input logic [1:0] kind, input logic [CNT_W-1:0] data);
    while (gaps_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == KIND_EVENT) prev_cnt = data;
    if (kind != KIND_NONE) sent++;
  endtask

  // Ticks carry junk in tdata; the block must ignore it.
  task automatic send_ticks(input int count);
    repeat (count) send_item(KIND_TICK, CNT_W'($urandom));
  endtask

  // Stop offering, wait for every pending result, then let the block settle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_magnets(input logic [MAG_W-1:0] value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic: mostly rotation runs (ticks, then an event whose count
  // mostly steps forward, sometimes back or unchanged, then maybe a query),
  // mixed with lone queries, wild counts, stray ticks and undefined kinds.
  task automatic random_items(input int count);
    int                 target;
    int                 r;
    int                 delta;
    logic signed [15:0] next_cnt;
    target = sent + count;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_ticks(($urandom_range(19) == 0) ? $urandom_range(150, 40) : $urandom_range(6));
        r = $urandom_range(99);
        if (r < 70) delta = $urandom_range(40, 1);
        else if (r < 88) delta = -int'($urandom_range(40, 1));
        else delta = 0;
        next_cnt = prev_cnt + 16'(delta);
        send_item(KIND_EVENT, next_cnt);
        if ($urandom_range(1) == 1) begin
          send_ticks($urandom_range(4));
          send_item(KIND_QUERY, CNT_W'($urandom));
        end
      end else if (r < 80) begin
        send_item(KIND_QUERY, CNT_W'($urandom));
      end else if (r < 90) begin
        send_item(KIND_EVENT, CNT_W'($urandom));
      end else if (r < 96) begin
        send_item(KIND_TICK, CNT_W'($urandom));
      end else begin
        send_item(KIND_NONE, CNT_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int               phase;
    logic [MAG_W-1:0] setting;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: period 10000000, six magnets.
    send_item(KIND_QUERY, '0);
    send_ticks(3);
    send_item(KIND_EVENT, 16'sh7fff);   // maximum count, forward
    send_item(KIND_QUERY, '1);
    send_item(KIND_EVENT, 16'sh7fff);   // equal count: reverse, zero period
    send_item(KIND_QUERY, '0);
    send_ticks(2);
    send_item(KIND_EVENT, 16'sh8000);   // minimum count, reverse wraps to index 5
    send_item(KIND_NONE, '1);           // ignored
    send_item(KIND_TICK, '1);
    send_item(KIND_QUERY, '0);

    // One magnet: index 5 now lies beyond the count, position saturates high.
    set_magnets(6'd1);
    send_item(KIND_TICK, '0);
    send_item(KIND_QUERY, '0);
    send_item(KIND_EVENT, 16'sd100);    // forward from beyond the count steps to 0
    send_item(KIND_TICK, '0);
    send_item(KIND_QUERY, '0);

    // Largest magnet count: reverse from index 0 wraps to 62.
    set_magnets(6'd63);
    send_item(KIND_EVENT, -16'sd5);
    send_item(KIND_QUERY, '0);

    // Zero magnets count as one.
    set_magnets(6'd0);
    send_item(KIND_QUERY, '0);
    send_item(KIND_EVENT, 16'sd40);
    send_item(KIND_QUERY, '0);

    // Random phases over several magnet counts; long stall in phase 1,
    // no idling at all in phase 3.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       setting = 6'd63;
        1:       setting = 6'd1;
        4:       setting = 6'd2;
        5:       setting = MAGNETS_RESET;
        default: setting = MAG_W'($urandom_range(62, 3));
      endcase
      set_magnets(setting);
      gaps_on <= (phase != 3);
      if (phase == 1) hold_token <= hold_token + 1;
      random_items(225);
    end

    drain_block();
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
